>>> rtl/stereo_biquad_first_order_cascade_defines.svh
// ----------------------------------------------------------------------------
// stereo biquad cascade assertion macros
// shared property shapes for the port checker
// ----------------------------------------------------------------------------
`ifndef STEREO_BIQUAD_FIRST_ORDER_CASCADE_DEFINES_SVH
`define STEREO_BIQUAD_FIRST_ORDER_CASCADE_DEFINES_SVH

// same-cycle implication
`define SBQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SBQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/sbq_pkg.sv
// ----------------------------------------------------------------------------
// sbq_pkg
// widths, register indexes and the control program of the filter sequencer
// ----------------------------------------------------------------------------
package sbq_pkg;

	localparam int CHANNELS       = 2;
	localparam int CH_W           = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CH_LEFT        = 0;
	localparam int CH_RIGHT       = 1;
	localparam int SAMPLE_WIDTH   = 24;
	localparam int COEF_FRAC_BITS = 28;
	localparam int COEF_WIDTH     = 32;
	localparam int DATA_WIDTH     = 32;
	localparam int PROD_WIDTH     = COEF_WIDTH + DATA_WIDTH;
	localparam int ACC_WIDTH      = PROD_WIDTH + 2;
	localparam int NUM_REGS       = 8;
	localparam int REG_IDX_W      = 3;
	localparam int PC_W           = 4;

	localparam logic [ACC_WIDTH-1:0] RND_HALF = ACC_WIDTH'(1) << (COEF_FRAC_BITS - 1);

	localparam logic [REG_IDX_W-1:0] REG_BQ_B0 = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_BQ_B1 = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_BQ_B2 = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_BQ_A1 = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BQ_A2 = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_SC_B0 = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SC_B1 = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SC_A1 = 3'd7;

	localparam logic [COEF_WIDTH-1:0] COEF_ONE  = COEF_WIDTH'(1) << COEF_FRAC_BITS;
	localparam logic [COEF_WIDTH-1:0] COEF_ZERO = '0;

	typedef enum logic [2:0] {
		OPND_X    = 3'd0,
		OPND_XD1  = 3'd1,
		OPND_XD2  = 3'd2,
		OPND_YD1  = 3'd3,
		OPND_YD2  = 3'd4,
		OPND_Y    = 3'd5,
		OPND_SIN  = 3'd6,
		OPND_SOUT = 3'd7
	} opnd_t;

	typedef struct packed {
		logic mac;
		logic clr;
		logic sub;
	} mac_ctl_t;

	typedef struct packed {
		logic                 mac;
		logic                 clr;
		logic                 sub;
		logic [REG_IDX_W-1:0] coef;
		opnd_t                opnd;
		logic                 fin_y;
		logic                 fin_z;
		logic                 jmp;
		logic [PC_W-1:0]      tgt;
	} ucode_t;

	localparam logic [PC_W-1:0] PC_START = '0;

	function automatic ucode_t uc_word(input logic mac, input logic clr, input logic sub,
			input logic [REG_IDX_W-1:0] coef, input opnd_t opnd, input logic fin_y,
			input logic fin_z, input logic jmp);
		ucode_t w;
		w.mac   = mac;
		w.clr   = clr;
		w.sub   = sub;
		w.coef  = coef;
		w.opnd  = opnd;
		w.fin_y = fin_y;
		w.fin_z = fin_z;
		w.jmp   = jmp;
		w.tgt   = PC_START;
		return w;
	endfunction

	// one channel per pass; the last step loops back for the next channel
	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		case (pc)
			4'd0:    w = uc_word(1'b1, 1'b1, 1'b0, REG_BQ_B0, OPND_X,    1'b0, 1'b0, 1'b0);
			4'd1:    w = uc_word(1'b1, 1'b0, 1'b0, REG_BQ_B1, OPND_XD1,  1'b0, 1'b0, 1'b0);
			4'd2:    w = uc_word(1'b1, 1'b0, 1'b0, REG_BQ_B2, OPND_XD2,  1'b0, 1'b0, 1'b0);
			4'd3:    w = uc_word(1'b1, 1'b0, 1'b1, REG_BQ_A1, OPND_YD1,  1'b0, 1'b0, 1'b0);
			4'd4:    w = uc_word(1'b1, 1'b0, 1'b1, REG_BQ_A2, OPND_YD2,  1'b0, 1'b0, 1'b0);
			4'd5:    w = uc_word(1'b0, 1'b0, 1'b0, REG_BQ_B0, OPND_X,    1'b0, 1'b0, 1'b0);
			4'd6:    w = uc_word(1'b0, 1'b0, 1'b0, REG_BQ_B0, OPND_X,    1'b1, 1'b0, 1'b0);
			4'd7:    w = uc_word(1'b1, 1'b1, 1'b0, REG_SC_B0, OPND_Y,    1'b0, 1'b0, 1'b0);
			4'd8:    w = uc_word(1'b1, 1'b0, 1'b0, REG_SC_B1, OPND_SIN,  1'b0, 1'b0, 1'b0);
			4'd9:    w = uc_word(1'b1, 1'b0, 1'b1, REG_SC_A1, OPND_SOUT, 1'b0, 1'b0, 1'b0);
			4'd10:   w = uc_word(1'b0, 1'b0, 1'b0, REG_BQ_B0, OPND_X,    1'b0, 1'b0, 1'b0);
			4'd11:   w = uc_word(1'b0, 1'b0, 1'b0, REG_BQ_B0, OPND_X,    1'b0, 1'b1, 1'b1);
			default: w = uc_word(1'b0, 1'b0, 1'b0, REG_BQ_B0, OPND_X,    1'b0, 1'b0, 1'b1);
		endcase
		return w;
	endfunction

endpackage

>>> rtl/sbq_in_if.sv
// ----------------------------------------------------------------------------
// sbq_in_if
// input sample pair channel, valid/ready
// ----------------------------------------------------------------------------
interface sbq_in_if;
	logic                                      valid;
	logic                                      ready;
	logic signed [sbq_pkg::SAMPLE_WIDTH-1:0]   left_in;
	logic signed [sbq_pkg::SAMPLE_WIDTH-1:0]   right_in;

	modport source (output valid, output left_in, output right_in, input ready);
	modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

>>> rtl/sbq_out_if.sv
// ----------------------------------------------------------------------------
// sbq_out_if
// filtered sample pair channel, valid/ready
// ----------------------------------------------------------------------------
interface sbq_out_if;
	logic                                      valid;
	logic                                      ready;
	logic signed [sbq_pkg::SAMPLE_WIDTH-1:0]   left_out;
	logic signed [sbq_pkg::SAMPLE_WIDTH-1:0]   right_out;

	modport source (output valid, output left_out, output right_out, input ready);
	modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

>>> rtl/sbq_cfg_if.sv
// ----------------------------------------------------------------------------
// sbq_cfg_if
// coefficient register write channel, valid/ready
// ----------------------------------------------------------------------------
interface sbq_cfg_if;
	logic                                   valid;
	logic                                   ready;
	logic [sbq_pkg::REG_IDX_W-1:0]          index;
	logic [sbq_pkg::COEF_WIDTH-1:0]         data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/stereo_biquad_first_order_cascade.sv
// ----------------------------------------------------------------------------
// stereo_biquad_first_order_cascade
// stereo direct-form-I biquad followed by a first-order section, fixed point
// ----------------------------------------------------------------------------
// usage:
//   samples: one left/right word per handshake, taken only while the block
//     is idle; ready drops for the whole filtering run
//   results: one filtered word per sample word, held in an output register
//     until the receiver takes it
//   cfg: coefficient writes, always ready; write only while the block is idle
// timing:
//   a 12-step control program runs once per channel on one shared
//   multiplier and accumulator, so an item takes 24 run cycles plus one
//   cycle to hand off and one idle cycle to accept: 26 cycles per word
//   results.valid rises 25 edges after the sample word is taken
//   each pass is eight products plus four steps waiting on the mac pipeline
//   a stalled receiver holds the output register; the next sample word is
//   taken and filtered meanwhile, and waits at hand-off until it drains
// reset:
//   filter history clears to zero, coefficients go to pass-through
//   (b0 = 1.0, others 0), the output register empties
// ----------------------------------------------------------------------------
module stereo_biquad_first_order_cascade (
	input  logic       clk,
	input  logic       arst_n,
	sbq_in_if.sink     samples,
	sbq_out_if.source  results,
	sbq_cfg_if.sink    cfg
);

	localparam int SW = sbq_pkg::SAMPLE_WIDTH;
	localparam int DW = sbq_pkg::DATA_WIDTH;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                                   state_q;
	logic [sbq_pkg::PC_W-1:0]                 pc_q;
	logic [sbq_pkg::CH_W-1:0]                 ch_q;
	logic                                     out_valid_q;

	logic signed [sbq_pkg::COEF_WIDTH-1:0]    coef_q [sbq_pkg::NUM_REGS];
	logic signed [SW-1:0]                     x_q    [sbq_pkg::CHANNELS];
	logic signed [SW-1:0]                     bxd1_q [sbq_pkg::CHANNELS];
	logic signed [SW-1:0]                     bxd2_q [sbq_pkg::CHANNELS];
	logic signed [DW-1:0]                     byd1_q [sbq_pkg::CHANNELS];
	logic signed [DW-1:0]                     byd2_q [sbq_pkg::CHANNELS];
	logic signed [DW-1:0]                     sin_q  [sbq_pkg::CHANNELS];
	logic signed [DW-1:0]                     sout_q [sbq_pkg::CHANNELS];
	logic signed [DW-1:0]                     y_q;
	logic signed [SW-1:0]                     res_q  [sbq_pkg::CHANNELS];
	logic signed [SW-1:0]                     out_q  [sbq_pkg::CHANNELS];

	sbq_pkg::ucode_t                          uw;
	sbq_pkg::mac_ctl_t                        mac_ctl;
	logic signed [DW-1:0]                     opnd;
	logic signed [DW-1:0]                     mac_res;
	logic                                     run;
	logic                                     in_take;
	logic                                     out_load;
	logic                                     last_ch;

	function automatic logic signed [SW-1:0] sat_sample(input logic signed [DW-1:0] v);
		logic [DW-SW:0] hi;
		hi = v[DW-1:SW-1];
		if (&hi || ~|hi) begin
			return v[SW-1:0];
		end else if (v[DW-1]) begin
			return {1'b1, {(SW-1){1'b0}}};
		end else begin
			return {1'b0, {(SW-1){1'b1}}};
		end
	endfunction

	assign run      = (state_q == ST_RUN);
	assign in_take  = samples.valid && samples.ready;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || results.ready);
	assign last_ch  = (ch_q == sbq_pkg::CH_W'(sbq_pkg::CHANNELS - 1));
	assign uw       = sbq_pkg::ucode_rom(pc_q);

	assign samples.ready     = (state_q == ST_IDLE);
	assign cfg.ready         = 1'b1;
	assign results.valid     = out_valid_q;
	assign results.left_out  = out_q[sbq_pkg::CH_LEFT];
	assign results.right_out = out_q[sbq_pkg::CH_RIGHT];

	// operand select and mac control
	always_comb begin
		case (uw.opnd)
			sbq_pkg::OPND_X:    opnd = DW'(x_q[ch_q]);
			sbq_pkg::OPND_XD1:  opnd = DW'(bxd1_q[ch_q]);
			sbq_pkg::OPND_XD2:  opnd = DW'(bxd2_q[ch_q]);
			sbq_pkg::OPND_YD1:  opnd = byd1_q[ch_q];
			sbq_pkg::OPND_YD2:  opnd = byd2_q[ch_q];
			sbq_pkg::OPND_Y:    opnd = y_q;
			sbq_pkg::OPND_SIN:  opnd = sin_q[ch_q];
			sbq_pkg::OPND_SOUT: opnd = sout_q[ch_q];
			default:            opnd = '0;
		endcase
		mac_ctl.mac = run && uw.mac;
		mac_ctl.clr = uw.clr;
		mac_ctl.sub = uw.sub;
	end

	sbq_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.coef   (coef_q[uw.coef]),
		.opnd   (opnd),
		.result (mac_res)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pc_q        <= sbq_pkg::PC_START;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						pc_q    <= sbq_pkg::PC_START;
						ch_q    <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (uw.jmp) begin
						if (last_ch) begin
							state_q <= ST_DONE;
						end else begin
							ch_q <= ch_q + 1'b1;
							pc_q <= uw.tgt;
						end
					end else begin
						pc_q <= pc_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// coefficients and filter history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < sbq_pkg::NUM_REGS; r++) begin
				coef_q[r] <= (r == sbq_pkg::REG_BQ_B0 || r == sbq_pkg::REG_SC_B0) ?
					sbq_pkg::COEF_ONE : sbq_pkg::COEF_ZERO;
			end
			for (int c = 0; c < sbq_pkg::CHANNELS; c++) begin
				bxd1_q[c] <= '0;
				bxd2_q[c] <= '0;
				byd1_q[c] <= '0;
				byd2_q[c] <= '0;
				sin_q[c]  <= '0;
				sout_q[c] <= '0;
			end
		end else begin
			if (cfg.valid) begin
				coef_q[cfg.index] <= cfg.data;
			end
			if (run && uw.fin_y) begin
				bxd2_q[ch_q] <= bxd1_q[ch_q];
				bxd1_q[ch_q] <= x_q[ch_q];
				byd2_q[ch_q] <= byd1_q[ch_q];
				byd1_q[ch_q] <= mac_res;
			end
			if (run && uw.fin_z) begin
				sin_q[ch_q]  <= y_q;
				sout_q[ch_q] <= mac_res;
			end
		end
	end

	// sample and result words
	always_ff @(posedge clk) begin
		if (in_take) begin
			x_q[sbq_pkg::CH_LEFT]  <= samples.left_in;
			x_q[sbq_pkg::CH_RIGHT] <= samples.right_in;
		end
		if (run && uw.fin_y) begin
			y_q <= mac_res;
		end
		if (run && uw.fin_z) begin
			res_q[ch_q] <= sat_sample(mac_res);
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

endmodule

>>> rtl/sbq_mac.sv
// ----------------------------------------------------------------------------
// sbq_mac
// shared multiply-accumulate unit with round-half-up and 32-bit saturation
// ----------------------------------------------------------------------------
module sbq_mac (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  sbq_pkg::mac_ctl_t                       ctl,
	input  logic signed [sbq_pkg::COEF_WIDTH-1:0]   coef,
	input  logic signed [sbq_pkg::DATA_WIDTH-1:0]   opnd,
	output logic signed [sbq_pkg::DATA_WIDTH-1:0]   result
);

	localparam int SH_W = sbq_pkg::ACC_WIDTH - sbq_pkg::COEF_FRAC_BITS;

	sbq_pkg::mac_ctl_t                              ctl_s1;
	logic signed [sbq_pkg::PROD_WIDTH-1:0]          prod_s1;
	logic signed [sbq_pkg::ACC_WIDTH-1:0]           acc_q;
	logic signed [sbq_pkg::ACC_WIDTH-1:0]           prod_ext;
	logic signed [sbq_pkg::ACC_WIDTH-1:0]           acc_base;
	logic signed [sbq_pkg::ACC_WIDTH-1:0]           acc_rnd;
	logic signed [SH_W-1:0]                         acc_sh;
	logic [SH_W-sbq_pkg::DATA_WIDTH:0]              acc_hi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= coef * opnd;
	end

	always_comb begin
		prod_ext = sbq_pkg::ACC_WIDTH'(prod_s1);
		acc_base = ctl_s1.clr ? '0 : acc_q;
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.mac) begin
			acc_q <= ctl_s1.sub ? (acc_base - prod_ext) : (acc_base + prod_ext);
		end
	end

	// round half up, drop fraction, clamp
	always_comb begin
		acc_rnd = acc_q + signed'(sbq_pkg::RND_HALF);
		acc_sh  = acc_rnd[sbq_pkg::ACC_WIDTH-1:sbq_pkg::COEF_FRAC_BITS];
		acc_hi  = acc_sh[SH_W-1:sbq_pkg::DATA_WIDTH-1];
		if (&acc_hi || ~|acc_hi) begin
			result = acc_sh[sbq_pkg::DATA_WIDTH-1:0];
		end else if (acc_sh[SH_W-1]) begin
			result = {1'b1, {(sbq_pkg::DATA_WIDTH-1){1'b0}}};
		end else begin
			result = {1'b0, {(sbq_pkg::DATA_WIDTH-1){1'b1}}};
		end
	end

endmodule

>>> rtl/sbq_checker.sv
// ----------------------------------------------------------------------------
// sbq_checker
// port-level checks on the stereo cascade, bound to the top level
// ----------------------------------------------------------------------------
`include "stereo_biquad_first_order_cascade_defines.svh"

module sbq_checker (
	input logic clk,
	input logic arst_n,
	input logic s_valid,
	input logic s_ready,
	input logic r_valid,
	input logic r_ready
);

	`SBQ_ASSERT_NXT(a_out_hold, r_valid && !r_ready, r_valid, "result word dropped while stalled")
	`SBQ_ASSERT_NXT(a_busy_next, s_valid && s_ready, !s_ready, "sample taken while still filtering")
	`SBQ_ASSERT_IMP(a_busy_two, $past(s_valid && s_ready, 2) && $past(arst_n, 2) && $past(arst_n, 1), !s_ready, "run ended too early")
	`SBQ_ASSERT_IMP(a_result_after_run, $rose(r_valid), $past(!s_ready), "result word without a run")

endmodule

bind stereo_biquad_first_order_cascade sbq_checker u_sbq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_valid (samples.valid),
	.s_ready (samples.ready),
	.r_valid (results.valid),
	.r_ready (results.ready)
);
